FILE: src/rspe_pkg.sv
// Shared types, constants and GF(256) arithmetic for the Reed-Solomon parity encoder.
package rspe_pkg;

    localparam int MAX_PARITY  = 30;
    localparam int LENGTH_HIGH = 30;
    localparam int LEN_CAP     = (MAX_PARITY < LENGTH_HIGH) ? MAX_PARITY : LENGTH_HIGH;
    localparam int LEN_W       = 5;
    localparam int CNT_W       = $clog2(MAX_PARITY + 1);
    localparam int IDX_W       = (MAX_PARITY > 1) ? $clog2(MAX_PARITY) : 1;
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = $clog2(QDEPTH);

    localparam logic [LEN_W-1:0] RESET_LENGTH = LEN_W'(10);
    localparam logic [8:0]       FIELD_POLY   = 9'h11D;
    localparam logic [7:0]       ALPHA        = 8'h02;

    typedef logic [7:0]                  byte_t;
    typedef byte_t [MAX_PARITY-1:0]      byte_vec_t;
    typedef logic [CNT_W-1:0]            cnt_t;
    typedef logic [LEN_W-1:0]            len_t;

    typedef struct packed {
        byte_t data;
        logic  last;
    } item_t;

    // Bit-serial GF(256) product, MSB of b first.
    function automatic byte_t gf_mul(input byte_t a, input byte_t b);
        byte_t acc;
        acc = '0;
        for (int bit_i = 7; bit_i >= 0; bit_i--) begin
            acc = {acc[6:0], 1'b0} ^ (acc[7] ? FIELD_POLY[7:0] : 8'h00);
            acc = acc ^ (b[bit_i] ? a : 8'h00);
        end
        return acc;
    endfunction

    // Register value clamped to 1..LEN_CAP.
    function automatic cnt_t eff_len(input len_t plen);
        cnt_t n;
        if (plen == '0)
            n = cnt_t'(1);
        else if (int'(plen) > LEN_CAP)
            n = cnt_t'(LEN_CAP);
        else
            n = cnt_t'(plen);
        return n;
    endfunction

endpackage

FILE: src/rspe_gen.sv
// Generator polynomial derivation: one root folded in per cycle.
module rspe_gen (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               restart,
    input  rspe_pkg::cnt_t     n,
    output rspe_pkg::byte_vec_t coeffs,
    output logic               ready
);
    import rspe_pkg::*;

    typedef enum logic [1:0] {ST_LOAD, ST_RUN, ST_READY} state_t;

    state_t    state_reg;
    byte_vec_t g_reg, g_next, g_init;
    byte_t     root_reg;
    cnt_t      step_reg;
    cnt_t      n_m1;
    byte_vec_t g_shift;

    assign n_m1    = n - cnt_t'(1);
    assign g_shift = g_reg >> 8;

    always_comb
    begin
        g_init = '0;
        g_init[n_m1[IDX_W-1:0]] = 8'h01;
        for (int j = 0; j < MAX_PARITY; j++)
        begin
            g_next[j] = gf_mul(g_reg[j], root_reg) ^ g_shift[j];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            step_reg  <= '0;
            root_reg  <= 8'h01;
            g_reg     <= '0;
        end
        else if (restart)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            unique case (state_reg)
                ST_LOAD:
                begin
                    g_reg     <= g_init;
                    root_reg  <= 8'h01;
                    step_reg  <= '0;
                    state_reg <= ST_RUN;
                end
                ST_RUN:
                begin
                    g_reg    <= g_next;
                    root_reg <= gf_mul(root_reg, ALPHA);
                    step_reg <= step_reg + cnt_t'(1);
                    if (step_reg == n_m1)
                        state_reg <= ST_READY;
                end
                ST_READY: ;
                default: state_reg <= ST_LOAD;
            endcase
        end
    end

    assign coeffs = g_reg;
    assign ready  = (state_reg == ST_READY);

endmodule

FILE: src/rspe_front.sv
// Input side: accepts beats into a two-entry queue toward the LFSR.
module rspe_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           restart,
    input  logic           gen_ready,
    input  logic           push,
    input  rspe_pkg::item_t in_item,
    output logic           full,
    output logic           q_valid,
    output rspe_pkg::item_t q_item,
    input  logic           q_pop
);
    import rspe_pkg::*;

    item_t                    mem_reg [QDEPTH];
    logic [QPTR_W-1:0]        wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]          count_reg, count_next;
    logic                     push_ok, pop_ok;

    assign full    = (count_reg == (QPTR_W + 1)'(QDEPTH)) | ~gen_ready;
    assign push_ok = push & ~full;
    assign q_valid = (count_reg != '0);
    assign pop_ok  = q_pop & q_valid;
    assign q_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push_ok & ~pop_ok)
            count_next = count_reg + (QPTR_W + 1)'(1);
        else if (pop_ok & ~push_ok)
            count_next = count_reg - (QPTR_W + 1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else if (restart)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_ok)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop_ok)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
            mem_reg[wr_ptr_reg] <= in_item;
    end

endmodule

FILE: src/rspe_back.sv
// LFSR remainder update and parity drain register.
module rspe_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               restart,
    input  logic               gen_ready,
    input  rspe_pkg::byte_vec_t coeffs,
    input  rspe_pkg::cnt_t     n,
    input  logic               q_valid,
    input  rspe_pkg::item_t    q_item,
    output logic               q_pop,
    input  logic               pop,
    output logic               empty,
    output rspe_pkg::byte_t    parity_byte,
    output logic               parity_last
);
    import rspe_pkg::*;

    byte_vec_t rem_reg, rem_next, rem_shift;
    byte_vec_t drain_reg;
    cnt_t      drain_cnt_reg;
    byte_t     fb;
    logic      pop_ok, drain_free, take;

    assign empty       = (drain_cnt_reg == '0);
    assign parity_byte = drain_reg[0];
    assign parity_last = (drain_cnt_reg == cnt_t'(1));
    assign pop_ok      = pop & ~empty;
    assign drain_free  = empty | (pop_ok & parity_last);
    assign take        = q_valid & gen_ready & (~q_item.last | drain_free);
    assign q_pop       = take;

    assign fb        = q_item.data ^ rem_reg[0];
    assign rem_shift = rem_reg >> 8;

    always_comb
    begin
        for (int i = 0; i < MAX_PARITY; i++)
        begin
            rem_next[i] = rem_shift[i] ^ gf_mul(coeffs[i], fb);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg       <= '0;
            drain_reg     <= '0;
            drain_cnt_reg <= '0;
        end
        else if (restart)
        begin
            rem_reg       <= '0;
            drain_cnt_reg <= '0;
        end
        else
        begin
            if (take)
                rem_reg <= q_item.last ? '0 : rem_next;
            if (take & q_item.last)
            begin
                drain_reg     <= rem_next;
                drain_cnt_reg <= n;
            end
            else if (pop_ok)
            begin
                drain_reg     <= drain_reg >> 8;
                drain_cnt_reg <= drain_cnt_reg - cnt_t'(1);
            end
        end
    end

endmodule

FILE: src/reed_solomon_parity_encoder.sv
// Top level: RS(GF(256), 0x11D) systematic parity encoder, queue-style ports.
// Throughput: one data beat per cycle while full is low; the LFSR updates all
// remainder bytes at once. A last beat's remainder goes via the queue to the drain;
// n parity beats follow, one per pop. A next block's last beat waits for the drain.
// Reset (async, rst_n low) and every parity_length write clear the remainder and
// rederive the generator: full stays high while it is rebuilt.
module reed_solomon_parity_encoder (
    input  logic                 clk,
    input  logic                 rst_n,
    // data side
    input  logic                 push,
    output logic                 full,
    input  logic [7:0]           data_byte,
    input  logic                 last,
    // parity side
    input  logic                 pop,
    output logic                 empty,
    output logic [7:0]           parity_byte,
    output logic                 parity_last,
    // config: parity_length
    input  logic                 wr_en,
    input  logic [4:0]           wr_data
);
    import rspe_pkg::*;

    len_t      plen_reg;
    cnt_t      n;
    byte_vec_t coeffs;
    logic      gen_ready;
    item_t     in_item, q_item;
    logic      q_valid, q_pop;

    // Parity length register; a write restarts everything.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            plen_reg <= RESET_LENGTH;
        else if (wr_en)
            plen_reg <= wr_data;
    end

    // Effective degree, clamped to 1..cap.
    assign n = eff_len(plen_reg);

    assign in_item.data = data_byte;
    assign in_item.last = last;

    // Generator coefficients, rebuilt root by root after reset/config.
    rspe_gen u_gen (
        .clk     (clk),
        .rst_n   (rst_n),
        .restart (wr_en),
        .n       (n),
        .coeffs  (coeffs),
        .ready   (gen_ready)
    );

    // Front: takes beats, buffers them so the LFSR can stall on the drain.
    rspe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .restart   (wr_en),
        .gen_ready (gen_ready),
        .push      (push),
        .in_item   (in_item),
        .full      (full),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    // Back: remainder LFSR; on a last beat the remainder moves to the drain.
    rspe_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .restart     (wr_en),
        .gen_ready   (gen_ready),
        .coeffs      (coeffs),
        .n           (n),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .pop         (pop),
        .empty       (empty),
        .parity_byte (parity_byte),
        .parity_last (parity_last)
    );

endmodule

FILE: src/rspe_checker.sv
// Port-level assertions for the parity encoder, bound to the top level.
module rspe_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       wr_en,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [7:0] parity_byte,
    input logic       parity_last
);

    // A config write rebuilds the generator, so no beat is taken next cycle.
    a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> full)
        else $error("input accepted right after config write");

    // A config write drops any pending parity.
    a_cfg_flush: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> empty)
        else $error("parity pending after config write");

    // A waiting parity beat holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop && !wr_en) |=>
            (!empty && $stable(parity_byte) && $stable(parity_last)))
        else $error("parity beat changed while stalled");

    // A non-final parity beat popped is followed by another.
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !parity_last && !wr_en) |=> !empty)
        else $error("parity burst ended without final beat");

endmodule

bind reed_solomon_parity_encoder rspe_checker u_rspe_checker (.*);

FILE: tb/rspe_tb_pkg.sv
// Scoreboard class with a GF(256) parity predictor for the Reed-Solomon encoder bench.
package rspe_tb_pkg;

    import rspe_pkg::*;

    typedef struct {
        byte_t value;
        logic  tail;
    } parity_beat_t;

    class rs_parity_scoreboard;

        byte_t        work_rem [MAX_PARITY];
        byte_t        gen_taps [MAX_PARITY];
        int           span;
        parity_beat_t owed_q [$];
        int           errors;

        function new();
            errors = 0;
            set_parity_length(RESET_LENGTH);
        endfunction

        // Shift-and-add product, LSB of b first, reduced by the field polynomial.
        function byte_t gf_times(input byte_t a, input byte_t b);
            byte_t prod;
            byte_t x;
            byte_t y;
            prod = '0;
            x = a;
            y = b;
            repeat (8)
            begin
                if (y[0])
                    prod ^= x;
                x = {x[6:0], 1'b0} ^ (x[7] ? FIELD_POLY[7:0] : 8'h00);
                y = y >> 1;
            end
            return prod;
        endfunction

        // Clamp, rebuild g(x) = prod (x + alpha^i), drop any block in progress.
        function void set_parity_length(input len_t plen);
            byte_t poly [MAX_PARITY+1];
            byte_t root;
            if (plen == '0)
                span = 1;
            else if (int'(plen) > LEN_CAP)
                span = LEN_CAP;
            else
                span = int'(plen);
            foreach (poly[k])
                poly[k] = '0;
            poly[0] = 8'h01;
            root = 8'h01;
            for (int i = 0; i < span; i++)
            begin
                for (int k = i + 1; k >= 1; k--)
                    poly[k] = poly[k-1] ^ gf_times(poly[k], root);
                poly[0] = gf_times(poly[0], root);
                root = gf_times(root, ALPHA);
            end
            // taps run highest order first, leading 1 dropped
            for (int j = 0; j < MAX_PARITY; j++)
            begin
                gen_taps[j] = (j < span) ? poly[span-1-j] : 8'h00;
                work_rem[j] = 8'h00;
            end
        endfunction

        function void note_data_beat(input byte_t data, input logic is_last);
            byte_t        fb;
            parity_beat_t pb;
            fb = data ^ work_rem[0];
            for (int i = 0; i + 1 < span; i++)
                work_rem[i] = work_rem[i+1];
            work_rem[span-1] = 8'h00;
            for (int i = 0; i < span; i++)
                work_rem[i] ^= gf_times(gen_taps[i], fb);
            if (is_last)
            begin
                for (int i = 0; i < span; i++)
                begin
                    pb.value = work_rem[i];
                    pb.tail  = (i == span - 1);
                    owed_q.insert(owed_q.size(), pb);
                    work_rem[i] = 8'h00;
                end
            end
        endfunction

        function void check_parity_beat(input byte_t value, input logic tail);
            parity_beat_t pb;
            if (owed_q.size() == 0)
            begin
                $error("unexpected parity beat: parity_byte %02h parity_last %0b", value, tail);
                errors++;
                return;
            end
            pb = owed_q.pop_front();
            if (value !== pb.value)
            begin
                $error("parity_byte: expected %02h, actual %02h", pb.value, value);
                errors++;
            end
            if (tail !== pb.tail)
            begin
                $error("parity_last: expected %0b, actual %0b", pb.tail, tail);
                errors++;
            end
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

    endclass

endpackage

FILE: tb/tb.sv
// Top-level bench for the Reed-Solomon parity encoder: directed and random blocks.
module tb;

    import rspe_tb_pkg::*;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       push        = 1'b0;
    logic [7:0] data_byte   = 8'h00;
    logic       last        = 1'b0;
    logic       pop         = 1'b0;
    logic       wr_en       = 1'b0;
    logic [4:0] wr_data     = 5'd0;
    logic       full;
    logic       empty;
    logic [7:0] parity_byte;
    logic       parity_last;

    // Idle behavior, percent of cycles; hold_left forces a long receiver hold-off.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;

    rs_parity_scoreboard parity_sb;

    reed_solomon_parity_encoder u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .data_byte   (data_byte),
        .last        (last),
        .pop         (pop),
        .empty       (empty),
        .parity_byte (parity_byte),
        .parity_last (parity_last),
        .wr_en       (wr_en),
        .wr_data     (wr_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Hard stop in case the block hangs or a parity beat never shows up.
    initial
    begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

    // Receiver: pick pop at each rising edge, judge the beat at the falling edge.
    // Between negedge and the next posedge neither pop nor empty can move, so the
    // check here sees exactly the beat that the next edge accepts.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                pop <= 1'b0;
                hold_left--;
            end
            else
                pop <= ($urandom_range(0, 99) >= recv_stall_pct);
            @(negedge clk);
            if (rst_n && pop && !empty)
                parity_sb.check_parity_beat(parity_byte, parity_last);
        end
    end

    // Offer one data beat, entered and left just after a rising edge. The random
    // gap comes first so push is never dropped and raised in the same step.
    task automatic send_beat(input logic [7:0] d, input logic is_last);
        int gap;
        gap = 0;
        while (gap < 8 && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push      <= 1'b1;
        data_byte <= d;
        last      <= is_last;
        // full seen at negedge is what the next edge samples
        do
            @(negedge clk);
        while (full);
        @(posedge clk);
        parity_sb.note_data_beat(d, is_last);
    endtask

    // Mostly random bytes, with the all-zero and all-one patterns mixed in.
    task automatic send_block(input int len, input logic close_block);
        logic [7:0] d;
        for (int k = 0; k < len; k++)
        begin
            case ($urandom_range(0, 9))
                0:       d = 8'h00;
                1:       d = 8'hFF;
                default: d = 8'($urandom_range(0, 255));
            endcase
            send_beat(d, close_block && (k == len - 1));
        end
    endtask

    // Wait until every owed parity beat is in, then allow settle time:
    // a trailing non-last beat gives no parity, so nothing else marks the block idle.
    task automatic wait_drained();
        push <= 1'b0;
        while (parity_sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // parity_length write: only once the block has drained; full covers the rebuild.
    task automatic write_length(input logic [4:0] v);
        wait_drained();
        wr_en   <= 1'b1;
        wr_data <= v;
        @(posedge clk);
        wr_en <= 1'b0;
        parity_sb.set_parity_length(v);
    endtask

    // One random phase: idle mix, parity length, then blocks of mostly short size.
    task automatic run_phase(input int send_pct, input int stall_pct,
                             input logic [4:0] plen, input int beats);
        int count;
        int blen;
        write_length(plen);
        @(negedge clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        @(posedge clk);
        count = 0;
        while (count < beats)
        begin
            blen = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 4);
            send_block(blen, 1'b1);
            count += blen;
        end
        // sometimes leave a block open; the next length write drops it
        if ($urandom_range(0, 1) == 1)
            send_block($urandom_range(1, 3), 1'b0);
    endtask

    initial
    begin
        parity_sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset generator (length 10): zero byte, all-ones last, lone last byte.
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b1);
        send_beat(8'h80, 1'b1);

        // Length 0 clamps to a single parity byte.
        write_length(5'd0);
        send_beat(8'h01, 1'b0);
        send_beat(8'h7F, 1'b1);

        // Length 31 clamps to the cap of 30.
        write_length(5'd31);
        send_beat(8'hAA, 1'b0);
        send_beat(8'h55, 1'b1);
        send_beat(8'hFF, 1'b1);

        write_length(5'd1);
        send_beat(8'hC3, 1'b1);

        // Write in the middle of a block: the partial remainder is thrown away.
        write_length(5'd30);
        send_beat(8'h12, 1'b0);
        send_beat(8'h34, 1'b0);
        write_length(5'd7);
        send_beat(8'h56, 1'b0);
        send_beat(8'h9A, 1'b1);

        // Back-to-back one-byte blocks at full length: each last waits for a drain.
        write_length(5'd30);
        send_beat(8'hFF, 1'b1);
        send_beat(8'h00, 1'b1);
        send_beat(8'h5A, 1'b1);

        // Random phases across the idle mixes.
        run_phase(0,  0,  5'($urandom_range(2, 9)), 48);
        run_phase(61, 0,  5'd30, 48);
        run_phase(0,  61, 5'($urandom_range(0, 31)), 48);
        run_phase(31, 31, 5'd10, 48);

        // Back-pressure: receiver holds off for a long stretch while the sender
        // keeps offering beats, so the parity drain stays taken, the queue fills and full rises.
        write_length(5'd16);
        @(negedge clk);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 400;
        @(posedge clk);
        for (int b = 0; b < 12; b++)
            send_block($urandom_range(1, 3), 1'b1);

        wait_drained();
        repeat (16) @(posedge clk);
        if (parity_sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: reed_solomon_parity_encoder.f
src/rspe_pkg.sv
src/rspe_gen.sv
src/rspe_front.sv
src/rspe_back.sv
src/reed_solomon_parity_encoder.sv
src/rspe_checker.sv
tb/rspe_tb_pkg.sv
tb/tb.sv
